@@ rtl/aging_priority_event_dispatcher_macros.svh @@
// Assertion macros for the aging priority event dispatcher.
`ifndef AGING_PRIORITY_EVENT_DISPATCHER_MACROS_SVH
`define AGING_PRIORITY_EVENT_DISPATCHER_MACROS_SVH
`ifndef SYNTHESIS
`define APED_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define APED_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`else
`define APED_ASSERT(label, clk, rst_n, prop, msg)
`define APED_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

@@ rtl/aped_pkg.sv @@
// Shared types and constants of the aging priority event dispatcher.
package aped_pkg;
  localparam int unsigned MaxEntriesDefault = 16;

  localparam logic [2:0] ReqAdd      = 3'd0;
  localparam logic [2:0] ReqRemove   = 3'd1;
  localparam logic [2:0] ReqSuspend  = 3'd2;
  localparam logic [2:0] ReqResume   = 3'd3;
  localparam logic [2:0] ReqReport   = 3'd4;
  localparam logic [2:0] ReqDispatch = 3'd5;

  localparam logic [1:0] StatOk       = 2'd0;
  localparam logic [1:0] StatFull     = 2'd1;
  localparam logic [1:0] StatNotFound = 2'd2;

  typedef struct packed {
    logic [2:0] req_type;
    logic [9:0] chan_id;
    logic [7:0] static_prio;
    logic       watch_read;
    logic       watch_write;
    logic       watch_except;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic       granted;
    logic [9:0] grant_id;
    logic       grant_read;
    logic       grant_write;
    logic       grant_except;
    logic [5:0] pending_total;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic clr;     // start of a scan
    logic scan;    // visit entry at scan index
    logic commit;  // apply the request
    logic age;     // aging and counting pass step
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last;    // scan index at last entry
  } dp_sts_t;
endpackage

@@ rtl/aging_priority_event_dispatcher.sv @@
// Top level of the aging priority event dispatcher.
// channel | dir | handshake
// req     | in  | req_valid_i / req_ready_o, payload req_i
// rsp     | out | rsp_valid_o / rsp_ready_i, payload rsp_o
// One request at a time: after accept, the result is set by one entry-table scan for
// lookup/selection, an apply step, and one pass for aging and counting.
// Reset clears valid, pending and suspend flags at once; no clearing pass.
// A stalled result holds the block until taken.
`include "aging_priority_event_dispatcher_macros.svh"
module aging_priority_event_dispatcher import aped_pkg::*; #(
  parameter int unsigned MaxEntries = MaxEntriesDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  req_t req_i,
  output logic rsp_valid_o,
  input  logic rsp_ready_i,
  output rsp_t rsp_o
);
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    busy;
  req_t    req_q;
  req_t    req_sel;

  // hold the request for the whole transaction
  always_ff @(posedge clk_i) begin
    if (req_valid_i && req_ready_o) req_q <= req_i;
  end
  assign req_sel = req_q;

  aped_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(req_valid_i), .in_ready_o(req_ready_o),
    .out_valid_o(rsp_valid_o), .out_ready_i(rsp_ready_i),
    .sts_i(sts), .cmd_o(cmd), .busy_o(busy)
  );

  aped_datapath #(.MaxEntries(MaxEntries)) u_dp (
    .clk_i, .rst_ni, .req_i(req_sel), .cmd_i(cmd), .sts_o(sts), .rsp_o
  );

  `APED_ASSERT(a_ready_idle, clk_i, rst_ni, !(req_ready_o && busy), "ready while busy")
  `APED_ASSERT(a_excl, clk_i, rst_ni, !(req_ready_o && rsp_valid_o), "ready with result")
  `APED_ASSERT_NEXT(a_hold, clk_i, rst_ni, rsp_valid_o && !rsp_ready_i, $stable(rsp_o), "stall")
endmodule

@@ rtl/aped_datapath.sv @@
// Entry table, scan registers and update logic of the dispatcher.
module aped_datapath import aped_pkg::*; #(
  parameter int unsigned MaxEntries = MaxEntriesDefault
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  req_t    req_i,
  input  dp_cmd_t cmd_i,
  output dp_sts_t sts_o,
  output rsp_t    rsp_o
);
  localparam int unsigned IdxW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;

  logic [MaxEntries-1:0] valid_q, susp_q;
  logic [2:0]  pend_q  [MaxEntries];
  logic [9:0]  id_q    [MaxEntries];
  logic [7:0]  base_q  [MaxEntries];
  logic [15:0] cur_q   [MaxEntries];
  logic [2:0]  mask_q  [MaxEntries];
  logic [15:0] rank_q  [MaxEntries];
  logic [15:0] add_cnt_q;

  logic [IdxW-1:0] idx_q;
  logic            free_fnd_q, id_fnd_q, win_fnd_q;
  logic [IdxW-1:0] free_q, hit_q, win_q;
  logic [15:0]     win_cur_q, win_age_q;
  logic [7:0]      win_base_q;
  logic [5:0]      cnt_q;

  logic [2:0]  ev;
  logic [15:0] age_i;
  logic        pend_i, beats;
  logic [7:0]  cnt_sum;
  rsp_t        rsp_cmt;

  assign ev     = {req_i.watch_except, req_i.watch_write, req_i.watch_read};
  assign pend_i = valid_q[idx_q] && (pend_q[idx_q] != 3'd0);
  assign age_i  = add_cnt_q - rank_q[idx_q];
  always_comb begin
    if (cur_q[idx_q] != win_cur_q) beats = cur_q[idx_q] > win_cur_q;
    else if (base_q[idx_q] != win_base_q) beats = base_q[idx_q] > win_base_q;
    else beats = age_i > win_age_q;
  end
  assign cnt_sum = 8'(cnt_q) + (valid_q[idx_q] ? 8'($countones(pend_q[idx_q])) : 8'd0);
  assign sts_o.last = (32'(idx_q) == MaxEntries - 1);

  // status and grant fields; pending total is filled in by the counting pass
  always_comb begin
    rsp_cmt = '0;
    case (req_i.req_type)
      ReqAdd: begin
        if (!free_fnd_q) rsp_cmt.status = StatFull;
      end
      ReqRemove, ReqSuspend, ReqResume, ReqReport: begin
        if (!id_fnd_q) rsp_cmt.status = StatNotFound;
      end
      ReqDispatch: begin
        if (win_fnd_q) begin
          rsp_cmt.granted      = 1'b1;
          rsp_cmt.grant_id     = id_q[win_q];
          rsp_cmt.grant_read   = pend_q[win_q][0];
          rsp_cmt.grant_write  = pend_q[win_q][1];
          rsp_cmt.grant_except = pend_q[win_q][2];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      susp_q     <= '0;
      for (int i = 0; i < MaxEntries; i++) pend_q[i] <= 3'd0;
      add_cnt_q  <= '0;
      idx_q      <= '0;
      free_fnd_q <= 1'b0;
      id_fnd_q   <= 1'b0;
      win_fnd_q  <= 1'b0;
      cnt_q      <= '0;
      rsp_o      <= '0;
    end else if (cmd_i.clr) begin
      idx_q      <= '0;
      free_fnd_q <= 1'b0;
      id_fnd_q   <= 1'b0;
      win_fnd_q  <= 1'b0;
      cnt_q      <= '0;
    end else if (cmd_i.scan) begin
      idx_q <= idx_q + 1'b1;
      if (!valid_q[idx_q] && !free_fnd_q) begin
        free_fnd_q <= 1'b1;
        free_q     <= idx_q;
      end
      if (valid_q[idx_q] && id_q[idx_q] == req_i.chan_id && !id_fnd_q) begin
        id_fnd_q <= 1'b1;
        hit_q    <= idx_q;
      end
      if (pend_i && (!win_fnd_q || beats)) begin
        win_fnd_q  <= 1'b1;
        win_q      <= idx_q;
        win_cur_q  <= cur_q[idx_q];
        win_base_q <= base_q[idx_q];
        win_age_q  <= age_i;
      end
    end else if (cmd_i.commit) begin
      rsp_o <= rsp_cmt;
      idx_q <= '0;
      case (req_i.req_type)
        ReqAdd: begin
          if (free_fnd_q) begin
            valid_q[free_q] <= 1'b1;
            id_q[free_q]    <= req_i.chan_id;
            base_q[free_q]  <= req_i.static_prio;
            cur_q[free_q]   <= 16'(req_i.static_prio);
            mask_q[free_q]  <= ev;
            pend_q[free_q]  <= 3'd0;
            susp_q[free_q]  <= 1'b0;
            rank_q[free_q]  <= add_cnt_q;
            add_cnt_q       <= add_cnt_q + 16'd1;
          end
        end
        ReqRemove, ReqSuspend, ReqResume, ReqReport: begin
          if (!id_fnd_q) begin
          end else if (req_i.req_type == ReqRemove) begin
            valid_q[hit_q] <= 1'b0;
            pend_q[hit_q]  <= 3'd0;
            susp_q[hit_q]  <= 1'b0;
          end else if (req_i.req_type == ReqSuspend) begin
            susp_q[hit_q] <= 1'b1;
            pend_q[hit_q] <= 3'd0;
          end else if (req_i.req_type == ReqResume) begin
            susp_q[hit_q] <= 1'b0;
          end else if (!susp_q[hit_q]) begin
            pend_q[hit_q] <= pend_q[hit_q] | (ev & mask_q[hit_q]);
          end
        end
        default: ;
      endcase
    end else if (cmd_i.age) begin
      // one entry a cycle: on a granted dispatch age pending losers and reset winner; count pending bits left
      idx_q <= idx_q + 1'b1;
      if (req_i.req_type == ReqDispatch && win_fnd_q) begin
        if (idx_q == win_q) begin
          cur_q[idx_q]  <= 16'(base_q[idx_q]);
          pend_q[idx_q] <= 3'd0;
        end else if (pend_i && cur_q[idx_q] != 16'hFFFF) begin
          cur_q[idx_q] <= cur_q[idx_q] + 16'd1;
        end
      end
      if (!(req_i.req_type == ReqDispatch && win_fnd_q && idx_q == win_q))
        cnt_q <= (cnt_sum > 8'd63) ? 6'd63 : cnt_sum[5:0];
      if (sts_o.last) begin
        rsp_o.pending_total <= (cnt_sum > 8'd63 && !(req_i.req_type == ReqDispatch
                                && win_fnd_q && idx_q == win_q)) ? 6'd63 :
                               ((req_i.req_type == ReqDispatch && win_fnd_q && idx_q == win_q)
                                ? cnt_q : cnt_sum[5:0]);
      end
    end
  end
endmodule

@@ rtl/aped_ctrl.sv @@
// Sequencing state machine of the dispatcher.
module aped_ctrl import aped_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o,
  output logic    busy_o
);
  localparam logic [2:0] StIdle = 3'd0, StScan = 3'd1, StApply = 3'd2,
                         StCount = 3'd3, StDone = 3'd4;
  logic [2:0] st_q, st_d;

  assign in_ready_o  = (st_q == StIdle);
  assign out_valid_o = (st_q == StDone);
  assign busy_o      = (st_q != StIdle);

  always_comb begin
    st_d  = st_q;
    cmd_o = '0;
    case (st_q)
      StIdle:  if (in_valid_i) begin st_d = StScan; cmd_o.clr = 1'b1; end
      StScan:  begin cmd_o.scan = 1'b1; if (sts_i.last) st_d = StApply; end
      StApply: begin cmd_o.commit = 1'b1; st_d = StCount; end
      StCount: begin cmd_o.age = 1'b1; if (sts_i.last) st_d = StDone; end
      StDone:  if (out_ready_i) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= StIdle;
    else st_q <= st_d;
  end
endmodule
